>>> design/llp_pkg.sv
// shared constants, codes and controller/datapath interface types for the
// ll(1) table-driven parser; no dependencies
package llp_pkg;

   // field and storage sizes
   localparam int NT_W        = 5;
   localparam int COL_W       = 5;
   localparam int PROD_W      = 6;
   localparam int POS_W       = 3;
   localparam int SYM_W       = 6;
   localparam int LEN_W       = 4;
   localparam int RHS_MAX     = 8;
   localparam int STACK_DEPTH = 64;
   localparam int SP_W        = 7;
   localparam int STK_AW      = 6;
   localparam int STEP_LIMIT  = 384;
   localparam int STEP_W      = 9;
   localparam int POPS_W      = 7;
   localparam int CNT_W       = 16;
   localparam int OUT_W       = 3;
   localparam int VERD_W      = 2;

   typedef enum logic [1:0] {
      MODE_LOAD_CELL = 2'd0,
      MODE_LOAD_SYM  = 2'd1,
      MODE_BEGIN     = 2'd2,
      MODE_TOKEN     = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      KIND_EXPAND  = 2'd0,
      KIND_EPSILON = 2'd1,
      KIND_POP     = 2'd2,
      KIND_SCAN    = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      OUT_MATCHED       = 3'd0,
      OUT_DISCARDED     = 3'd1,
      OUT_TERM_MISMATCH = 3'd2,
      OUT_END_MISMATCH  = 3'd3,
      OUT_IGNORED       = 3'd4,
      OUT_OVERFLOW      = 3'd5
   } outcome_type;

   typedef enum logic [1:0] {
      VERD_ONGOING  = 2'd0,
      VERD_CLEAN    = 2'd1,
      VERD_ERRORS   = 2'd2,
      VERD_NOT_DONE = 2'd3
   } verdict_type;

   // datapath operations
   typedef enum logic [4:0] {
      OP_NONE, OP_LOAD_CELL, OP_LOAD_SYM, OP_BEGIN, OP_BEGIN2, OP_TOKEN,
      OP_RD_TOP, OP_RD_CELL, OP_RD_LEN, OP_RD_RHS, OP_EPSILON, OP_POP_ERR,
      OP_EXPAND, OP_PUSH, OP_MATCH, OP_SCAN, OP_HALT, OP_OVERFLOW
   } op_type;

   typedef struct packed {
      op_type      op;
      logic        emit;
      outcome_type outcome;
      logic        started;
   } cmd_type;

   typedef struct packed {
      logic     halted;
      logic     sp_zero;
      logic     steps_at_limit;
      logic     top_is_term;
      logic     top_eq_col;
      logic     top_is_end;
      logic     exp_overflow;
      logic     push_done;
      logic     scan_started;
      logic     rsp_free;
      kind_type kind;
   } status_type;

endpackage

>>> design/llp_ctrl.sv
// parser controller: one-hot sequencer that walks the table-action loop
// depends on llp_pkg
module llp_ctrl
   import llp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  mode_type   req_mode,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [10:0] {
      S_IDLE  = 11'b00000000001,
      S_BEGIN = 11'b00000000010,
      S_TOP   = 11'b00000000100,
      S_TOPW  = 11'b00000001000,
      S_CELL  = 11'b00000010000,
      S_LEN   = 11'b00000100000,
      S_PUSH  = 11'b00001000000,
      S_PUSHW = 11'b00010000000,
      S_EMIT  = 11'b00100000000,
      S_SPARE = 11'b01000000000,
      S_SPAR2 = 11'b10000000000
   } state_type;

   state_type   state_ff, state_in;
   outcome_type outcome_ff, outcome_in;
   logic        started_ff, started_in;

   assign req_tready = (state_ff == S_IDLE);

   // next state and command
   always_comb begin
      state_in   = state_ff;
      outcome_in = outcome_ff;
      started_in = started_ff;
      cmd        = '{op: OP_NONE, emit: 1'b0, outcome: outcome_ff, started: started_ff};
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               case (req_mode)
                  MODE_LOAD_CELL: cmd.op = OP_LOAD_CELL;
                  MODE_LOAD_SYM:  cmd.op = OP_LOAD_SYM;
                  MODE_BEGIN: begin
                     cmd.op   = OP_BEGIN;
                     state_in = S_BEGIN;
                  end
                  default: begin
                     started_in = 1'b0;
                     if (status.halted) begin
                        outcome_in = OUT_IGNORED;
                        state_in   = S_EMIT;
                     end else begin
                        cmd.op   = OP_TOKEN;
                        state_in = S_TOP;
                     end
                  end
               endcase
            end
         end
         S_BEGIN: begin
            cmd.op   = OP_BEGIN2;
            state_in = S_IDLE;
         end
         S_TOP: begin
            if (status.sp_zero || status.steps_at_limit) begin
               cmd.op     = OP_OVERFLOW;
               outcome_in = OUT_OVERFLOW;
               state_in   = S_EMIT;
            end else begin
               cmd.op   = OP_RD_TOP;
               state_in = S_TOPW;
            end
         end
         S_TOPW: begin
            if (status.top_is_term) begin
               state_in = S_EMIT;
               if (status.top_eq_col) begin
                  cmd.op     = OP_MATCH;
                  outcome_in = OUT_MATCHED;
               end else begin
                  cmd.op     = OP_HALT;
                  outcome_in = status.top_is_end ? OUT_END_MISMATCH : OUT_TERM_MISMATCH;
               end
            end else begin
               cmd.op   = OP_RD_CELL;
               state_in = S_CELL;
            end
         end
         S_CELL: begin
            case (status.kind)
               KIND_EPSILON: begin
                  cmd.op   = OP_EPSILON;
                  state_in = S_TOP;
               end
               KIND_POP: begin
                  cmd.op   = OP_POP_ERR;
                  state_in = S_TOP;
               end
               KIND_SCAN: begin
                  cmd.op     = OP_SCAN;
                  outcome_in = OUT_DISCARDED;
                  started_in = status.scan_started;
                  state_in   = S_EMIT;
               end
               default: begin
                  cmd.op   = OP_RD_LEN;
                  state_in = S_LEN;
               end
            endcase
         end
         S_LEN: begin
            if (status.exp_overflow) begin
               cmd.op     = OP_HALT;
               outcome_in = OUT_OVERFLOW;
               state_in   = S_EMIT;
            end else begin
               cmd.op   = OP_EXPAND;
               state_in = S_PUSH;
            end
         end
         S_PUSH: begin
            if (status.push_done) begin
               state_in = S_TOP;
            end else begin
               cmd.op   = OP_RD_RHS;
               state_in = S_PUSHW;
            end
         end
         S_PUSHW: begin
            cmd.op   = OP_PUSH;
            state_in = S_PUSH;
         end
         S_EMIT: begin
            if (status.rsp_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      outcome_ff <= outcome_in;
      started_ff <= started_in;
   end

endmodule

>>> design/llp_dpath.sv
// parser datapath: parse table, production store, symbol stack, counters
// and result register; depends on llp_pkg
module llp_dpath
   import llp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   output status_type           status,
   input  logic [NT_W-1:0]      req_nonterminal,
   input  logic [COL_W-1:0]     req_column,
   input  logic [1:0]           req_entry_kind,
   input  logic [PROD_W-1:0]    req_production,
   input  logic [POS_W-1:0]     req_position,
   input  logic [SYM_W-1:0]     req_symbol,
   input  logic [LEN_W-1:0]     req_rhs_length,
   input  logic                 csr_wen,
   input  logic [NT_W-1:0]      csr_wdata,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [OUT_W-1:0]     rsp_token_outcome,
   output logic [POPS_W-1:0]    rsp_pops_recovered,
   output logic                 rsp_scan_started,
   output logic [VERD_W-1:0]    rsp_verdict,
   output logic [CNT_W-1:0]     rsp_token_number
);

   // memories
   logic [1+PROD_W:0]  cell_mem  [NT_W'(0):(1<<(NT_W+COL_W))-1];
   logic [SYM_W-1:0]   rhs_mem   [0:(1<<(PROD_W+POS_W))-1];
   logic [LEN_W-1:0]   len_mem   [0:(1<<PROD_W)-1];
   logic [SYM_W-1:0]   stack_mem [0:STACK_DEPTH-1];

   logic [1+PROD_W:0]  cell_q;
   logic [SYM_W-1:0]   rhs_q;
   logic [LEN_W-1:0]   len_q;
   logic [SYM_W-1:0]   top_q;

   logic [SP_W-1:0]    sp_ff, sp_in;
   logic [STEP_W-1:0]  steps_ff, steps_in;
   logic [POPS_W-1:0]  pops_ff, pops_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               scanning_ff, scanning_in;
   logic               was_scan_ff, was_scan_in;
   logic               err_ff, err_in;
   logic               halted_ff, halted_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [LEN_W-1:0]   push_ff, push_in;
   logic [NT_W-1:0]    start_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]   out_ff;
   logic [POPS_W-1:0]  rpops_ff;
   logic               rscan_ff;
   logic [VERD_W-1:0]  verd_ff, verd_in;
   logic [CNT_W-1:0]   rcnt_ff;

   logic [LEN_W-1:0]   rl;
   logic [LEN_W-1:0]   load_len;
   logic [PROD_W-1:0]  cell_prod;
   logic [SP_W:0]      exp_sum;
   logic [POS_W-1:0]   rhs_pos;
   logic               stk_we;
   logic [STK_AW-1:0]  stk_waddr;
   logic [SYM_W-1:0]   stk_wdata;
   logic [SP_W-1:0]    sp_dec;

   assign cell_prod = cell_q[PROD_W-1:0];
   assign rl        = (len_q > LEN_W'(RHS_MAX)) ? LEN_W'(RHS_MAX) : len_q;
   assign load_len  = (req_rhs_length > LEN_W'(RHS_MAX)) ? LEN_W'(RHS_MAX) : req_rhs_length;
   assign exp_sum   = {1'b0, sp_ff} + (SP_W+1)'(rl);
   assign rhs_pos   = POS_W'(push_ff - LEN_W'(1));
   assign sp_dec    = sp_ff - SP_W'(1);

   // status toward the controller
   always_comb begin
      status.halted         = halted_ff;
      status.sp_zero        = (sp_ff == '0);
      status.steps_at_limit = (steps_ff >= STEP_W'(STEP_LIMIT));
      status.top_is_term    = ~top_q[SYM_W-1];
      status.top_eq_col     = (top_q[COL_W-1:0] == col_ff);
      status.top_is_end     = (top_q == '0);
      status.exp_overflow   = (exp_sum > (SP_W+1)'(STACK_DEPTH + 1));
      status.push_done      = (push_ff == '0);
      status.scan_started   = ~(was_scan_ff && (steps_ff == '0));
      status.rsp_free       = ~rsp_valid_ff | rsp_tready;
      status.kind           = kind_type'(cell_q[1+PROD_W:PROD_W]);
   end

   // verdict from the state after this token's updates
   always_comb begin
      if (!halted_ff) begin
         verd_in = VERD_ONGOING;
      end else if (sp_ff == '0 && cnt_ff != '0) begin
         verd_in = err_ff ? VERD_ERRORS : VERD_CLEAN;
      end else begin
         verd_in = VERD_NOT_DONE;
      end
   end

   // parser state updates
   always_comb begin
      sp_in       = sp_ff;
      steps_in    = steps_ff;
      pops_in     = pops_ff;
      cnt_in      = cnt_ff;
      scanning_in = scanning_ff;
      was_scan_in = was_scan_ff;
      err_in      = err_ff;
      halted_in   = halted_ff;
      col_in      = col_ff;
      push_in     = push_ff;
      case (cmd.op)
         OP_BEGIN: begin
            sp_in       = SP_W'(2);
            scanning_in = 1'b0;
            err_in      = 1'b0;
            halted_in   = 1'b0;
            cnt_in      = '0;
         end
         OP_TOKEN: begin
            if (cnt_ff != '1) cnt_in = cnt_ff + CNT_W'(1);
            was_scan_in = scanning_ff;
            scanning_in = 1'b0;
            pops_in     = '0;
            steps_in    = '0;
            col_in      = req_column;
         end
         OP_EPSILON: begin
            sp_in    = sp_dec;
            steps_in = steps_ff + STEP_W'(1);
         end
         OP_POP_ERR: begin
            sp_in    = sp_dec;
            steps_in = steps_ff + STEP_W'(1);
            err_in   = 1'b1;
            if (pops_ff != '1) pops_in = pops_ff + POPS_W'(1);
         end
         OP_EXPAND: begin
            sp_in    = sp_dec;
            steps_in = steps_ff + STEP_W'(1);
            push_in  = rl;
         end
         OP_PUSH: begin
            sp_in   = sp_ff + SP_W'(1);
            push_in = push_ff - LEN_W'(1);
         end
         OP_MATCH: begin
            sp_in = sp_dec;
            if (sp_dec == '0) halted_in = 1'b1;
         end
         OP_SCAN: begin
            err_in      = 1'b1;
            scanning_in = 1'b1;
            if (col_ff == '0) halted_in = 1'b1;
         end
         OP_HALT: halted_in = 1'b1;
         OP_OVERFLOW: begin
            halted_in = 1'b1;
            if (sp_ff == '0) sp_in = SP_W'(1);
         end
         default: ;
      endcase
   end

   // result register: loads on emit, drains on the consumer's ready
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff        <= '0;
         scanning_ff  <= 1'b0;
         err_ff       <= 1'b0;
         halted_ff    <= 1'b1;
         cnt_ff       <= '0;
         start_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         was_scan_ff  <= 1'b0;
         steps_ff     <= '0;
         pops_ff      <= '0;
         push_ff      <= '0;
      end else begin
         sp_ff        <= sp_in;
         scanning_ff  <= scanning_in;
         err_ff       <= err_in;
         halted_ff    <= halted_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         was_scan_ff  <= was_scan_in;
         steps_ff     <= steps_in;
         pops_ff      <= pops_in;
         push_ff      <= push_in;
         if (csr_wen) start_ff <= csr_wdata;
      end
   end

   // payload registers; an ignored token reports no recoveries
   always_ff @(posedge clock) begin
      col_ff <= col_in;
      if (cmd.emit) begin
         out_ff   <= cmd.outcome;
         rpops_ff <= (cmd.outcome == OUT_IGNORED) ? '0 : pops_ff;
         rscan_ff <= cmd.started;
         verd_ff  <= verd_in;
         rcnt_ff  <= cnt_ff;
      end
   end

   // parse table and production store
   always_ff @(posedge clock) begin
      if (cmd.op == OP_LOAD_CELL) begin
         cell_mem[{req_nonterminal, req_column}] <= {req_entry_kind, req_production};
      end
      if (cmd.op == OP_RD_CELL) begin
         cell_q <= cell_mem[{top_q[NT_W-1:0], col_ff}];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_LOAD_SYM) begin
         rhs_mem[{req_production, req_position}] <= req_symbol;
      end
      if (cmd.op == OP_RD_RHS) begin
         rhs_q <= rhs_mem[{cell_prod, rhs_pos}];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_LOAD_SYM) begin
         len_mem[req_production] <= load_len;
      end
      if (cmd.op == OP_RD_LEN) begin
         len_q <= len_mem[cell_prod];
      end
   end

   // symbol stack write mux
   always_comb begin
      stk_we    = 1'b0;
      stk_waddr = sp_ff[STK_AW-1:0];
      stk_wdata = rhs_q;
      case (cmd.op)
         OP_BEGIN: begin
            stk_we    = 1'b1;
            stk_waddr = '0;
            stk_wdata = '0;
         end
         OP_BEGIN2: begin
            stk_we    = 1'b1;
            stk_waddr = STK_AW'(1);
            stk_wdata = {1'b1, start_ff};
         end
         OP_PUSH: stk_we = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stack_mem[stk_waddr] <= stk_wdata;
      end
      if (cmd.op == OP_RD_TOP) begin
         top_q <= stack_mem[sp_dec[STK_AW-1:0]];
      end
   end

   assign rsp_tvalid         = rsp_valid_ff;
   assign rsp_token_outcome  = out_ff;
   assign rsp_pops_recovered = rpops_ff;
   assign rsp_scan_started   = rscan_ff;
   assign rsp_verdict        = verd_ff;
   assign rsp_token_number   = rcnt_ff;

   // stack never grows past its depth
   a_sp_bound: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= SP_W'(STACK_DEPTH))
      else $error("stack pointer beyond depth");

   // a push only lands below the top of the stack memory
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_PUSH) |-> (sp_ff < SP_W'(STACK_DEPTH)))
      else $error("push into a full stack");

   // a new result never overwrites one that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || rsp_tready))
      else $error("result overwritten");

   // reading the top needs a non-empty stack
   a_top_nonempty: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_RD_TOP) |-> (sp_ff != '0))
      else $error("top read on empty stack");

endmodule

>>> design/ll1_table_driven_parser.sv
// top level of the ll(1) table-driven parser: stream ports, field packing
// and the controller/datapath pair; depends on llp_pkg, llp_ctrl, llp_dpath
//
// LL(1) predictive parser with panic-mode recovery. Table cell loads,
// production symbol loads and begin items give no result; each token item
// gives one result beat. Load items are written as they are accepted, and a
// begin writes the end marker and then the start symbol to the stack. A token
// is accepted and the stack top is fetched; every table action it triggers
// then reads the cell and fetches the new top, an expansion adding one length
// read, a read and a write per pushed symbol and a step to close the push (the
// stack and production store each have a single port); the result is posted
// once the result register holds no unread beat. The result register lets a
// finished result wait while the next item is accepted. start_symbol is taken
// from csr_wdata when csr_wen is high and read at each begin.
module ll1_table_driven_parser
   import llp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // nonterminal[4:0] column[9:5] entry_kind[11:10] production[17:12]
   // position[20:18] symbol[26:21] rhs_length[30:27], bit 31 zero
   input  logic [31:0] req_tdata,
   // mode[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // token_outcome[2:0] pops_recovered[9:3] scan_started[10] verdict[12:11]
   // token_number[28:13], bits 31:29 zero
   output logic [31:0] rsp_tdata,
   input  logic        csr_wen,
   input  logic [4:0]  csr_wdata
);

   cmd_type            cmd;
   status_type         status;
   logic [OUT_W-1:0]   token_outcome;
   logic [POPS_W-1:0]  pops_recovered;
   logic               scan_started;
   logic [VERD_W-1:0]  verdict;
   logic [CNT_W-1:0]   token_number;

   llp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_mode   (mode_type'(req_tuser)),
      .status     (status),
      .cmd        (cmd)
   );

   llp_dpath u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_nonterminal    (req_tdata[4:0]),
      .req_column         (req_tdata[9:5]),
      .req_entry_kind     (req_tdata[11:10]),
      .req_production     (req_tdata[17:12]),
      .req_position       (req_tdata[20:18]),
      .req_symbol         (req_tdata[26:21]),
      .req_rhs_length     (req_tdata[30:27]),
      .csr_wen            (csr_wen),
      .csr_wdata          (csr_wdata),
      .rsp_tvalid         (rsp_tvalid),
      .rsp_tready         (rsp_tready),
      .rsp_token_outcome  (token_outcome),
      .rsp_pops_recovered (pops_recovered),
      .rsp_scan_started   (scan_started),
      .rsp_verdict        (verdict),
      .rsp_token_number   (token_number)
   );

   // result packing
   assign rsp_tdata = {3'b000, token_number, verdict, scan_started, pops_recovered,
                       token_outcome};

endmodule

>>> bench/tb_ll1_table_driven_parser.sv
// testbench for ll1_table_driven_parser: fills the parse table and production
// store, runs directed and random parses and checks every result beat against
// an in-bench predictor; depends on llp_pkg and the parser rtl
`timescale 1ns / 1ps

module tb_ll1_table_driven_parser;
   import llp_pkg::*;

   localparam int WATCH_LIMIT = 40000;
   localparam int ITEM_TARGET = 500;

   typedef struct packed {
      mode_type   mode;
      logic [4:0] nonterminal;
      logic [4:0] column;
      kind_type   kind;
      logic [5:0] production;
      logic [2:0] position;
      logic [5:0] symbol;
      logic [3:0] rhs_length;
   } req_item_type;

   typedef struct packed {
      outcome_type outcome;
      logic [6:0]  pops;
      logic        started;
      verdict_type verdict;
      logic [15:0] count;
   } token_result_type;

   // parse state that a token item can change
   typedef struct packed {
      logic [63:0][5:0] stk;
      logic [6:0]       sp;
      logic             scanning;
      logic             err;
      logic             halted;
      logic [15:0]      count;
   } parse_state_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        csr_wen = 1'b0;
   logic [4:0]  csr_wdata = '0;

   // predictor copy of the stores and registers
   kind_type        tbl_kind [1024];
   logic [5:0]      tbl_prod [1024];
   logic [5:0]      prod_syms [512];
   logic [3:0]      prod_len [64];
   logic [4:0]      start_nt = '0;
   parse_state_type pstate;

   token_result_type pending_results[$];
   int               errors = 0;
   int               watch = 0;
   int               beats_sent = 0;
   bit               calm = 1'b0;

   ll1_table_driven_parser DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_wen(csr_wen), .csr_wdata(csr_wdata)
   );

   always #6 clock = ~clock;

   // grammar subset: nonterminals and columns 0..3 and 28..31
   function automatic logic [4:0] pick5(logic [2:0] r);
      return {r[2], r[2], r[2], r[1:0]};
   endfunction

   // productions 0..7 and 56..63
   function automatic logic [5:0] pick_prod(logic [3:0] r);
      return {r[3], r[3], r[3], r[2:0]};
   endfunction

   // keep terminals common so the stack does not only grow
   function automatic logic [5:0] pick_sym();
      logic [4:0] v;
      v = pick5(3'($urandom));
      return {1'($urandom_range(2) == 0), v};
   endfunction

   function automatic verdict_type verdict_of(parse_state_type s);
      if (!s.halted) return VERD_ONGOING;
      if (s.sp == 0 && s.count > 0) return s.err ? VERD_ERRORS : VERD_CLEAN;
      return VERD_NOT_DONE;
   endfunction

   function automatic token_result_type finish_token(parse_state_type s, outcome_type o,
                                                     int pops, bit started);
      token_result_type r;
      r.outcome = o;
      r.pops    = (pops > 127) ? 7'd127 : pops[6:0];
      r.started = started;
      r.verdict = verdict_of(s);
      r.count   = s.count;
      return r;
   endfunction

   // run one token through the stack and table
   function automatic token_result_type parse_token(inout parse_state_type s,
                                                    input logic [4:0] col);
      int       pops;
      int       rl;
      int       top;
      int       sp;
      kind_type k;
      logic [5:0] p;
      bit       was_scanning;
      bit       started;
      pops = 0;
      if (s.halted) return finish_token(s, OUT_IGNORED, 0, 1'b0);
      if (s.count != 16'hffff) s.count++;
      was_scanning = s.scanning;
      s.scanning = 1'b0;
      for (int steps = 0; ; steps++) begin
         sp = s.sp;
         if (sp == 0 || sp > STACK_DEPTH || steps >= STEP_LIMIT) begin
            s.halted = 1'b1;
            if (sp == 0) s.sp = 7'd1;
            return finish_token(s, OUT_OVERFLOW, pops, 1'b0);
         end
         top = s.stk[sp-1];
         if (top < 32) begin
            s.halted = 1'b1;
            if (top == col) begin
               s.sp--;
               if (s.sp != 0) s.halted = 1'b0;
               return finish_token(s, OUT_MATCHED, pops, 1'b0);
            end
            return finish_token(s, (top == 0) ? OUT_END_MISMATCH : OUT_TERM_MISMATCH,
                                pops, 1'b0);
         end
         k = tbl_kind[(top - 32) * 32 + col];
         p = tbl_prod[(top - 32) * 32 + col];
         case (k)
            KIND_EPSILON: begin
               s.sp--;
            end
            KIND_POP: begin
               s.sp--;
               s.err = 1'b1;
               if (pops < 127) pops++;
            end
            KIND_SCAN: begin
               started = !(was_scanning && steps == 0);
               s.err = 1'b1;
               s.scanning = 1'b1;
               if (col == 0) s.halted = 1'b1;
               return finish_token(s, OUT_DISCARDED, pops, started);
            end
            default: begin
               rl = prod_len[p];
               if (rl > RHS_MAX) rl = RHS_MAX;
               if (sp - 1 + rl > STACK_DEPTH) begin
                  s.halted = 1'b1;
                  return finish_token(s, OUT_OVERFLOW, pops, 1'b0);
               end
               s.sp--;
               for (int i = rl; i > 0; i--) begin
                  s.stk[s.sp] = prod_syms[p * 8 + i - 1];
                  s.sp++;
               end
            end
         endcase
      end
   endfunction

   // predictor update for one accepted beat
   task automatic predict_beat(req_item_type it);
      token_result_type r;
      case (it.mode)
         MODE_LOAD_CELL: begin
            tbl_kind[it.nonterminal * 32 + it.column] = it.kind;
            tbl_prod[it.nonterminal * 32 + it.column] = it.production;
         end
         MODE_LOAD_SYM: begin
            prod_syms[it.production * 8 + it.position] = it.symbol;
            prod_len[it.production] = (it.rhs_length > RHS_MAX) ? 4'd8 : it.rhs_length;
         end
         MODE_BEGIN: begin
            pstate.stk[0] = 6'd0;
            pstate.stk[1] = 6'd32 + start_nt;
            pstate.sp = 7'd2;
            pstate.scanning = 1'b0;
            pstate.err = 1'b0;
            pstate.halted = 1'b0;
            pstate.count = '0;
         end
         default: begin
            r = parse_token(pstate, it.column);
            pending_results.insert(pending_results.size(), r);
         end
      endcase
   endtask

   function automatic req_item_type random_item(mode_type m);
      req_item_type it;
      it = req_item_type'($bits(req_item_type)'({$urandom, $urandom}));
      it.mode = m;
      return it;
   endfunction

   task automatic send_beat(req_item_type it);
      while (!calm && $urandom_range(99) < 24) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= it.mode;
      req_tdata  <= {1'b0, it.rhs_length, it.symbol, it.position, it.production,
                     it.kind, it.column, it.nonterminal};
      do @(posedge clock); while (!req_tready);
      beats_sent++;
      predict_beat(it);
   endtask

   task automatic send_token(logic [4:0] col);
      req_item_type it;
      it = random_item(MODE_TOKEN);
      it.column = col;
      send_beat(it);
   endtask

   task automatic send_begin();
      send_beat(random_item(MODE_BEGIN));
   endtask

   // a column that the current parse would match, else a random one
   function automatic logic [4:0] matching_column();
      parse_state_type  t;
      token_result_type r;
      logic [4:0]       c;
      logic [2:0]       base;
      base = 3'($urandom);
      for (int i = 0; i < 8; i++) begin
         c = pick5(base + 3'(i));
         t = pstate;
         r = parse_token(t, c);
         if (r.outcome == OUT_MATCHED) return c;
      end
      return pick5(3'($urandom));
   endfunction

   task automatic load_cell(logic [4:0] nt, logic [4:0] col);
      req_item_type it;
      int           w;
      it = random_item(MODE_LOAD_CELL);
      it.nonterminal = nt;
      it.column = col;
      it.production = pick_prod(4'($urandom));
      w = $urandom_range(99);
      it.kind = (w < 60) ? KIND_EXPAND : (w < 80) ? KIND_EPSILON :
                (w < 90) ? KIND_POP : KIND_SCAN;
      send_beat(it);
   endtask

   task automatic load_symbol(logic [5:0] prod, logic [2:0] pos, logic [3:0] len);
      req_item_type it;
      it = random_item(MODE_LOAD_SYM);
      it.production = prod;
      it.position = pos;
      it.rhs_length = len;
      it.symbol = pick_sym();
      send_beat(it);
   endtask

   // every position that the length reaches is loaded, at least one beat
   task automatic load_production(logic [5:0] prod, logic [3:0] len);
      int n;
      n = (len > 4'd8) ? 8 : (len == 4'd0) ? 1 : int'(len);
      for (int pos = 0; pos < n; pos++) load_symbol(prod, 3'(pos), len);
   endtask

   task automatic load_random_production(logic [5:0] prod);
      logic [3:0] len;
      len = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(3));
      load_production(prod, len);
   endtask

   // change the start symbol only once the block has gone quiet
   task automatic set_start(logic [4:0] v);
      @(negedge clock);
      req_tvalid <= 1'b0;
      wait (pending_results.size() == 0);
      repeat (10) @(negedge clock);
      csr_wen   <= 1'b1;
      csr_wdata <= v;
      @(negedge clock);
      csr_wen   <= 1'b0;
      start_nt = v;
   endtask

   task automatic report(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      errors++;
   endtask

   // result checker
   always @(posedge clock) begin
      token_result_type got;
      token_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.outcome = outcome_type'(rsp_tdata[2:0]);
         got.pops    = rsp_tdata[9:3];
         got.started = rsp_tdata[10];
         got.verdict = verdict_type'(rsp_tdata[12:11]);
         got.count   = rsp_tdata[28:13];
         if (pending_results.size() == 0) begin
            report("unexpected beat", rsp_tdata, 0);
         end else begin
            want = pending_results.pop_front();
            if (got.outcome !== want.outcome) report("token_outcome", got.outcome, want.outcome);
            if (got.pops !== want.pops) report("pops_recovered", got.pops, want.pops);
            if (got.started !== want.started) report("scan_started", got.started, want.started);
            if (got.verdict !== want.verdict) report("verdict", got.verdict, want.verdict);
            if (got.count !== want.count) report("token_number", got.count, want.count);
            if (rsp_tdata[31:29] !== 3'b000) report("rsp pad bits", rsp_tdata[31:29], 0);
         end
      end
   end

   // result side backpressure
   always @(negedge clock) begin
      rsp_tready <= calm || ($urandom_range(99) >= 24);
   end

   // watchdog on cycles with no accepted beat
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset) watch <= 0;
      else watch <= watch + 1;
      if (watch >= WATCH_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic test_tokens_before_begin();
      send_token(5'd0);
      send_token(5'd31);
      send_token($urandom);
   endtask

   task automatic test_fill_grammar();
      for (int nt = 0; nt < 8; nt++)
         for (int col = 0; col < 8; col++) load_cell(pick5(3'(nt)), pick5(3'(col)));
      for (int p = 0; p < 16; p++) load_random_production(pick_prod(4'(p)));
   endtask

   task automatic test_directed_parse();
      set_start(5'd31);
      send_begin();
      send_token(5'd0);
      send_token(matching_column());
      send_token(5'd31);
      set_start(5'd0);
      send_begin();
      for (int i = 0; i < 5; i++) send_token(matching_column());
      // restart in the middle of a parse
      send_begin();
      send_token(matching_column());
      // empty and oversized right sides
      load_production(6'd63, 4'd0);
      load_production(6'd62, 4'd15);
      load_production(6'd61, 4'd8);
      send_begin();
      send_token(5'd0);
   endtask

   task automatic test_random_parses();
      int n;
      while (beats_sent < ITEM_TARGET) begin
         calm = (beats_sent >= 250 && beats_sent < 330);
         if ($urandom_range(7) == 0) set_start(pick5(3'($urandom)));
         if ($urandom_range(5) == 0) load_cell(pick5(3'($urandom)), pick5(3'($urandom)));
         if ($urandom_range(9) == 0) load_random_production(pick_prod(4'($urandom)));
         send_begin();
         n = $urandom_range(30, 1);
         for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 75) send_token(matching_column());
            else if ($urandom_range(29) == 0) send_begin();
            else send_token(pick5(3'($urandom)));
            if (pstate.halted && $urandom_range(3) != 0) break;
         end
      end
      calm = 1'b0;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      pstate = '0;
      pstate.halted = 1'b1;
      test_tokens_before_begin();
      test_fill_grammar();
      test_directed_parse();
      test_random_parses();
      @(negedge clock);
      req_tvalid <= 1'b0;
      wait (pending_results.size() == 0);
      repeat (40) @(posedge clock);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
